### sv/interval_merger_macros.svh
// Assertion helpers for the interval merger
// Both macros expect i_clk and i_rst_n in the enclosing scope.
`ifndef INTERVAL_MERGER_MACROS_SVH
`define INTERVAL_MERGER_MACROS_SVH

// clocked assertion, disabled while the active-low reset is low
`define IM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// implication shorthand
`define IM_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> cons) \
        else $error(msg);

`endif

### sv/im_pkg.sv
package im_pkg;

    localparam int MaxIntervals = 32;
    localparam int ValueBits    = 32;
    localparam int IdxBits      = $clog2(MaxIntervals);
    localparam int CntBits      = $clog2(MaxIntervals + 1);

    typedef logic [ValueBits-1:0] t_value;
    typedef logic [IdxBits-1:0]   t_idx;
    typedef logic [CntBits-1:0]   t_cnt;

    typedef struct packed {
        logic signed [ValueBits-1:0] interval_start;
        logic signed [ValueBits-1:0] interval_end;
        logic                        last_item;
    } t_in_word;

    typedef struct packed {
        logic signed [ValueBits-1:0] merged_start;
        logic signed [ValueBits-1:0] merged_end;
        logic                        last_result;
        logic                        dropped_flag;
    } t_out_word;

    // one stored interval, keys with sign bit flipped
    typedef struct packed {
        t_value s;
        t_value e;
    } t_entry;

    // memory port request from the controller
    typedef struct packed {
        logic   rd_en;
        t_idx   rd_addr;
        logic   wr_en;
        t_idx   wr_addr;
        t_entry wr_data;
    } t_mem_req;

    function automatic t_value to_key(input t_value v);
        to_key = v ^ {1'b1, {(ValueBits-1){1'b0}}};
    endfunction

    // a sorts before or equal to b
    function automatic logic entry_le(input t_entry a, input t_entry b);
        entry_le = (a.s < b.s) || ((a.s == b.s) && (a.e <= b.e));
    endfunction

endpackage

### sv/im_ram.sv
module im_ram #(
    parameter int Depth = 32,
    parameter int Width = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [$clog2(Depth)-1:0] i_rd_addr,
    output logic [Width-1:0]         o_rd_data,
    input  logic                     i_wr_en,
    input  logic [$clog2(Depth)-1:0] i_wr_addr,
    input  logic [Width-1:0]         i_wr_data
);

    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

### sv/im_ctrl.sv
module im_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  im_pkg::t_in_word   i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output im_pkg::t_out_word  o_data,
    output im_pkg::t_mem_req   o_mem,
    input  im_pkg::t_entry     i_rd_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT_RD,
        ST_SHIFT_CMP,
        ST_SCAN_RD,
        ST_SCAN,
        ST_EMIT
    } t_state;

    t_state           r_state, n_state;
    im_pkg::t_cnt     r_count, n_count;
    logic             r_ovf, n_ovf;
    im_pkg::t_cnt     r_pos, n_pos;       // insertion hole / next scan address
    im_pkg::t_entry   r_new, n_new;       // interval being inserted
    logic             r_last, n_last;
    im_pkg::t_entry   r_cur, n_cur;       // running merged group
    logic             r_have, n_have;
    logic             r_final, n_final;
    logic             r_ovalid, n_ovalid;
    im_pkg::t_out_word r_odata, n_odata;
    im_pkg::t_mem_req n_mem;

    im_pkg::t_entry   w_in;
    im_pkg::t_entry   w_done;
    logic             w_accept;
    logic             w_slot_free;

    assign w_in.s = im_pkg::to_key(i_data.interval_start);
    assign w_in.e = im_pkg::to_key(i_data.interval_end);
    assign w_done.s = im_pkg::to_key(r_cur.s);
    assign w_done.e = im_pkg::to_key(r_cur.e);

    // input stays closed while a result word waits
    assign o_ready     = (r_state == ST_IDLE) && !r_ovalid;
    assign w_accept    = i_valid && o_ready;
    assign w_slot_free = !r_ovalid || i_ready;
    assign o_valid = r_ovalid;
    assign o_data  = r_odata;
    assign o_mem   = n_mem;

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_ovf    = r_ovf;
        n_pos    = r_pos;
        n_new    = r_new;
        n_last   = r_last;
        n_cur    = r_cur;
        n_have   = r_have;
        n_final  = r_final;
        n_odata  = r_odata;
        n_ovalid = r_ovalid && !i_ready;
        n_mem    = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_new  = w_in;
                    n_last = i_data.last_item;
                    n_pos  = r_count;
                    if (r_count == im_pkg::t_cnt'(im_pkg::MaxIntervals)) begin
                        n_ovf = 1'b1;
                        n_pos = '0;
                        n_state = i_data.last_item ? ST_SCAN_RD : ST_IDLE;
                    end else if (r_count == '0) begin
                        n_mem.wr_en   = 1'b1;
                        n_mem.wr_addr = '0;
                        n_mem.wr_data = w_in;
                        n_count = im_pkg::t_cnt'(1);
                        n_pos   = '0;
                        n_state = i_data.last_item ? ST_SCAN_RD : ST_IDLE;
                    end else begin
                        n_state = ST_SHIFT_RD;
                    end
                end
            end
            ST_SHIFT_RD: begin
                n_mem.rd_en   = 1'b1;
                n_mem.rd_addr = im_pkg::t_idx'(r_pos - im_pkg::t_cnt'(1));
                n_state = ST_SHIFT_CMP;
            end
            ST_SHIFT_CMP: begin
                n_mem.wr_en   = 1'b1;
                n_mem.wr_addr = r_pos[im_pkg::IdxBits-1:0];
                if (r_pos == '0 || im_pkg::entry_le(i_rd_data, r_new)) begin
                    n_mem.wr_data = r_new;
                    n_count = r_count + im_pkg::t_cnt'(1);
                    n_pos   = '0;
                    n_state = r_last ? ST_SCAN_RD : ST_IDLE;
                end else begin
                    n_mem.wr_data = i_rd_data;
                    n_pos = r_pos - im_pkg::t_cnt'(1);
                    // at the head the hole is filled next cycle without a read
                    if (r_pos != im_pkg::t_cnt'(1)) begin
                        n_mem.rd_en   = 1'b1;
                        n_mem.rd_addr = im_pkg::t_idx'(r_pos - im_pkg::t_cnt'(2));
                    end
                end
            end
            ST_SCAN_RD: begin
                n_mem.rd_en   = 1'b1;
                n_mem.rd_addr = '0;
                n_pos   = im_pkg::t_cnt'(1);
                n_have  = 1'b0;
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (r_have && (i_rd_data.s > r_cur.e)) begin
                    // entry opens a new group; it stays on the read port through emit
                    n_final = 1'b0;
                    n_state = ST_EMIT;
                end else begin
                    if (!r_have) begin
                        n_cur = i_rd_data;
                    end else if (i_rd_data.e > r_cur.e) begin
                        n_cur.e = i_rd_data.e;
                    end
                    n_have = 1'b1;
                    if (r_pos >= r_count) begin
                        n_final = 1'b1;
                        n_state = ST_EMIT;
                    end else begin
                        n_mem.rd_en   = 1'b1;
                        n_mem.rd_addr = r_pos[im_pkg::IdxBits-1:0];
                        n_pos = r_pos + im_pkg::t_cnt'(1);
                    end
                end
            end
            ST_EMIT: begin
                if (w_slot_free) begin
                    n_ovalid = 1'b1;
                    n_odata.merged_start = w_done.s;
                    n_odata.merged_end   = w_done.e;
                    n_odata.last_result  = r_final;
                    n_odata.dropped_flag = r_ovf;
                    if (r_final) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_pos   = '0;
                        n_have  = 1'b0;
                        n_state = ST_IDLE;
                    end else begin
                        n_cur = i_rd_data;
                        if (r_pos >= r_count) begin
                            n_final = 1'b1;
                        end else begin
                            n_mem.rd_en   = 1'b1;
                            n_mem.rd_addr = r_pos[im_pkg::IdxBits-1:0];
                            n_pos = r_pos + im_pkg::t_cnt'(1);
                            n_state = ST_SCAN;
                        end
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_ovalid <= 1'b0;
            r_have   <= 1'b0;
            r_final  <= 1'b0;
            r_pos    <= '0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovf    <= n_ovf;
            r_have   <= n_have;
            r_pos    <= n_pos;
            r_final  <= n_final;
            r_ovalid <= n_ovalid;
        end
        r_new   <= n_new;
        r_last  <= n_last;
        r_cur   <= n_cur;
        r_odata <= n_odata;
    end

endmodule

### sv/interval_merger.sv
// Insert: an empty table takes the word directly and a full table drops it; else
// the k entries above the insertion point shift up one slot (one memory read and one write per cycle).
// After the last word: ST_SCAN_RD starts the scan, ST_SCAN walks the stored entries and
// ST_EMIT sends each merged word; each word is held until taken, and input stays closed until then.
// Reset (synchronous, active low) empties the table and clears the drop
// flag; table contents are not cleared.
module interval_merger (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  im_pkg::t_in_word  i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output im_pkg::t_out_word o_data
);

    im_pkg::t_mem_req w_mem;
    im_pkg::t_entry   w_rd;

    im_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_data    (i_data),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_data    (o_data),
        .o_mem     (w_mem),
        .i_rd_data (w_rd)
    );

    im_ram #(
        .Depth (im_pkg::MaxIntervals),
        .Width ($bits(im_pkg::t_entry))
    ) u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (w_mem.rd_en),
        .i_rd_addr (w_mem.rd_addr),
        .o_rd_data (w_rd),
        .i_wr_en   (w_mem.wr_en),
        .i_wr_addr (w_mem.wr_addr),
        .i_wr_data (w_mem.wr_data)
    );

endmodule

### sv/im_checker.sv
`include "interval_merger_macros.svh"

module im_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_ready,
    input im_pkg::t_in_word  i_data,
    input logic              o_valid,
    input logic              i_ready,
    input im_pkg::t_out_word o_data
);

    `IM_IMPLY(a_hold, o_valid && !i_ready, ##1 (o_valid && $stable(o_data)), "word not held")
    `IM_ASSERT(a_no_accept_while_out, !(o_valid && o_ready), "input open while word waits")
    `IM_IMPLY(a_last_busy, i_valid && o_ready && i_data.last_item, ##1 !o_ready, "no merge pass")

endmodule

bind interval_merger im_checker u_im_checker (.*);

### bench/tb_interval_merger.sv
module tb_interval_merger;

    localparam int WatchdogLimit = 20000;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    im_pkg::t_in_word  in_word;
    logic              out_valid;
    logic              out_ready;
    im_pkg::t_out_word out_word;

    interval_merger u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .o_ready (in_ready),
        .i_data  (in_word),
        .o_valid (out_valid),
        .i_ready (out_ready),
        .o_data  (out_word)
    );

    always begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // pending input words; a word flagged in pause_q waits until all results are out
    im_pkg::t_in_word  send_q[$];
    bit                pause_q[$];
    im_pkg::t_out_word merged_q[$];

    // predictor state: entries kept as sign-flipped keys, sorted
    logic [im_pkg::ValueBits-1:0] key_s[$];
    logic [im_pkg::ValueBits-1:0] key_e[$];
    bit                           dropped;

    int  errors;
    int  idle_cycles;
    bit  hold_sink;
    int  sink_gap;
    int  src_gap;

    task automatic report(input string what);
        errors++;
        $display("mismatch: %s", what);
    endtask

    function automatic logic [im_pkg::ValueBits-1:0] flip(
        input logic [im_pkg::ValueBits-1:0] v);
        return v ^ {1'b1, {(im_pkg::ValueBits-1){1'b0}}};
    endfunction

    // insert one interval and, on the last word, queue the merged intervals
    task automatic merge_predict(input im_pkg::t_in_word w);
        logic [im_pkg::ValueBits-1:0] s, e, cs, ce;
        int pos;
        im_pkg::t_out_word r;
        s = flip(w.interval_start);
        e = flip(w.interval_end);
        if (key_s.size() >= im_pkg::MaxIntervals) begin
            dropped = 1'b1;
        end else begin
            pos = key_s.size();
            while (pos > 0 && !(key_s[pos-1] < s ||
                   (key_s[pos-1] == s && key_e[pos-1] <= e)))
                pos--;
            key_s.insert(pos, s);
            key_e.insert(pos, e);
        end
        if (!w.last_item) return;
        cs = key_s[0];
        ce = key_e[0];
        for (int i = 1; i < key_s.size(); i++) begin
            if (key_s[i] <= ce) begin
                if (key_e[i] > ce) ce = key_e[i];
            end else begin
                r = '{flip(cs), flip(ce), 1'b0, dropped};
                merged_q.insert(merged_q.size(), r);
                cs = key_s[i];
                ce = key_e[i];
            end
        end
        r = '{flip(cs), flip(ce), 1'b1, dropped};
        merged_q.insert(merged_q.size(), r);
        key_s.delete();
        key_e.delete();
        dropped = 1'b0;
    endtask

    function automatic logic [31:0] rand_value(input int mode);
        case (mode)
            0: return $urandom;
            1: return 32'h7fffffff - $urandom_range(0, 3);
            2: return 32'h80000000 + $urandom_range(0, 3);
            default: return $urandom_range(0, 200) - 100;
        endcase
    endfunction

    task automatic add_word(input logic [31:0] s, input logic [31:0] e, input bit last);
        im_pkg::t_in_word w;
        w.interval_start = s;
        w.interval_end   = e;
        w.last_item      = last;
        send_q.insert(send_q.size(), w);
        pause_q.insert(pause_q.size(), 1'b0);
    endtask

    task automatic add_set(input int n);
        int mode;
        logic [31:0] s;
        mode = $urandom_range(0, 9);
        for (int i = 0; i < n; i++) begin
            if (mode < 6) begin
                s = $urandom_range(0, 200) - 100;
                add_word(s, s + $urandom_range(0, 20), i == n - 1);
            end else if (mode < 8) begin
                add_word(rand_value($urandom_range(0, 3)), rand_value($urandom_range(0, 3)),
                         i == n - 1);
            end else begin
                add_word($urandom, $urandom, i == n - 1);
            end
        end
    endtask

    // driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            src_gap  <= 0;
        end else if (!in_valid || in_ready) begin
            if (src_gap > 0) begin
                in_valid <= 1'b0;
                src_gap  <= src_gap - 1;
            end else if (send_q.size() > 0 && pause_q[0] &&
                         (merged_q.size() > 0 || (in_valid && in_ready))) begin
                in_valid <= 1'b0;
            end else if (send_q.size() > 0) begin
                in_word  <= send_q.pop_front();
                void'(pause_q.pop_front());
                in_valid <= 1'b1;
                src_gap  <= ($urandom_range(0, 9) == 0) ? $urandom_range(3, 25) :
                            ($urandom_range(0, 2) == 0 ? $urandom_range(0, 2) : 0);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            sink_gap  <= 0;
        end else if (hold_sink) begin
            out_ready <= 1'b0;
        end else if (sink_gap > 0) begin
            out_ready <= 1'b0;
            sink_gap  <= sink_gap - 1;
        end else begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                sink_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) :
                            $urandom_range(1, 3);
        end
    end

    // monitor, predictor update and watchdog
    always @(posedge clk) begin
        im_pkg::t_out_word exp_w;
        if (rst_n) begin
            if (in_valid && in_ready)
                merge_predict(in_word);
            if (out_valid && out_ready) begin
                if (merged_q.size() == 0) begin
                    report("unexpected word");
                end else begin
                    exp_w = merged_q.pop_front();
                    if (out_word.merged_start !== exp_w.merged_start)
                        report($sformatf("start %0d exp %0d", out_word.merged_start,
                                         exp_w.merged_start));
                    if (out_word.merged_end !== exp_w.merged_end)
                        report($sformatf("end %0d exp %0d", out_word.merged_end,
                                         exp_w.merged_end));
                    if (out_word.last_result !== exp_w.last_result)
                        report("last_result");
                    if (out_word.dropped_flag !== exp_w.dropped_flag)
                        report("dropped_flag");
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > WatchdogLimit) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        errors      = 0;
        idle_cycles = 0;
        hold_sink   = 1'b0;
        dropped     = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_word     = '0;
        out_ready   = 1'b0;

        // directed: single interval, extremes, touching, inverted, ties
        add_word(32'h80000000, 32'h7fffffff, 1'b1);
        add_word(32'h7fffffff, 32'h80000000, 1'b1);
        add_word(10, 20, 1'b0);
        add_word(20, 30, 1'b0);
        add_word(31, 40, 1'b0);
        add_word(5, 5, 1'b1);
        add_word(0, 10, 1'b0);
        add_word(0, 3, 1'b0);
        add_word(2, -5, 1'b0);
        add_word(-1, 0, 1'b1);
        add_word(32'hffffffff, 32'h0, 1'b0);
        add_word(32'h55555555, 32'haaaaaaaa, 1'b0);
        add_word(32'haaaaaaaa, 32'h55555555, 1'b1);
        // overflow set with the last word dropped too
        for (int i = 0; i < im_pkg::MaxIntervals + 2; i++)
            add_word(i * 3, i * 3 + 1, i == im_pkg::MaxIntervals + 1);
        pause_q[pause_q.size() - im_pkg::MaxIntervals - 2] = 1'b1;

        while (send_q.size() < 360) begin
            case ($urandom_range(0, 9))
                0: add_set($urandom_range(im_pkg::MaxIntervals - 1, im_pkg::MaxIntervals + 3));
                1: add_set(1);
                default: add_set($urandom_range(2, 12));
            endcase
            if ($urandom_range(0, 7) == 0)
                pause_q[pause_q.size() - 1] = 1'b1;
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // long receiver hold-off while the sender keeps offering
        repeat (300) @(posedge clk);
        hold_sink <= 1'b1;
        repeat (400) @(posedge clk);
        hold_sink <= 1'b0;

        wait (send_q.size() == 0 && !in_valid);
        wait (merged_q.size() == 0);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### filelist.f
+incdir+sv
sv/im_pkg.sv
sv/im_ram.sv
sv/im_ctrl.sv
sv/interval_merger.sv
sv/im_checker.sv
bench/tb_interval_merger.sv
